### rtl/core/assert_macros.svh
// Assertion helpers shared by the core's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CLAFC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define CLAFC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

### rtl/core/clafc_pkg.sv
`default_nettype none
package clafc_pkg;

   localparam int FEATURES    = 64;
   localparam int VALUE_LANES = 4;
   localparam int MAX_LANES   = 4;
   localparam int FEAT_IDX_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam logic [8:0] FEATURES_LIM = 9'(FEATURES);

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;
   localparam int QCNT_W  = 2;

   localparam logic signed [33:0] MAX32_W = 34'sd2147483647;
   localparam logic signed [33:0] MIN32_W = -34'sd2147483648;
   localparam logic signed [48:0] MAX48_W = 49'sd140737488355327;
   localparam logic signed [48:0] MIN48_W = -49'sd140737488355328;

   typedef struct packed {
      logic                          first_step;
      logic [5:0]                    feature_index;
      logic                          in_range;
      logic [15:0]                   query_feature;
      logic [15:0]                   key_feature;
      logic [VALUE_LANES-1:0][15:0]  value;
      logic                          last_feature;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_ACC
   } back_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > MAX32_W) begin
         return 32'sh7FFFFFFF;
      end else if (v < MIN32_W) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      if (v > MAX48_W) begin
         return 48'sh7FFFFFFFFFFF;
      end else if (v < MIN48_W) begin
         return 48'sh800000000000;
      end else begin
         return v[47:0];
      end
   endfunction

endpackage
`default_nettype wire

### rtl/core/causal_linear_attention_forward_core.sv
//  channel | direction | handshake            | beat carries
//  req_    | in        | req_valid/req_ready  | one feature of one time step
//  rsp_    | out       | rsp_valid/rsp_ready  | four numerators and denominator
//
//  An item goes through four steps in the back end: table read, row and key-sum
//  update, write back beside the query multiply, accumulate. The back end pops no
//  new item until that four-step sequence ends; the front register and 2-deep
//  queue accept up to 3 items ahead. Reset is synchronous and clears control and
//  the accumulators; the row tables hold garbage until a first-step item writes
//  them. A stalled rsp_ beat holds only the step's final item.
`default_nettype none
module causal_linear_attention_forward_core
   import clafc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_first_step,
   input  wire logic [5:0]  req_feature_index,
   input  wire logic [15:0] req_query_feature,
   input  wire logic [15:0] req_key_feature,
   input  wire logic [15:0] req_value_lane0,
   input  wire logic [15:0] req_value_lane1,
   input  wire logic [15:0] req_value_lane2,
   input  wire logic [15:0] req_value_lane3,
   input  wire logic        req_last_feature,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [47:0]      rsp_numerator0,
   output logic [47:0]      rsp_numerator1,
   output logic [47:0]      rsp_numerator2,
   output logic [47:0]      rsp_numerator3,
   output logic [47:0]      rsp_denominator
);

   // front to queue
   logic     push_valid, push_ready;
   item_type push_item;
   // queue to back end
   logic     head_valid, pop;
   item_type head_item;
   logic [MAX_LANES-1:0][47:0] numerator;

   // accept and classify each beat
   clafc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .first_step    (req_first_step),
      .feature_index (req_feature_index),
      .query_feature (req_query_feature),
      .key_feature   (req_key_feature),
      .value_lane0   (req_value_lane0),
      .value_lane1   (req_value_lane1),
      .value_lane2   (req_value_lane2),
      .value_lane3   (req_value_lane3),
      .last_feature  (req_last_feature),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   // decouple front and back so each side can stall on its own
   clafc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .head_valid (head_valid),
      .pop        (pop),
      .head_item  (head_item)
   );

   // update rows, accumulate, hold the result beat until taken
   clafc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_numerator   (numerator),
      .rsp_denominator (rsp_denominator)
   );

   assign rsp_numerator0 = numerator[0];
   assign rsp_numerator1 = numerator[1];
   assign rsp_numerator2 = numerator[2];
   assign rsp_numerator3 = numerator[3];

endmodule
`default_nettype wire

### rtl/core/clafc_front.sv
`default_nettype none
module clafc_front
   import clafc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        first_step,
   input  wire logic [5:0]  feature_index,
   input  wire logic [15:0] query_feature,
   input  wire logic [15:0] key_feature,
   input  wire logic [15:0] value_lane0,
   input  wire logic [15:0] value_lane1,
   input  wire logic [15:0] value_lane2,
   input  wire logic [15:0] value_lane3,
   input  wire logic        last_feature,
   output logic             push_valid,
   input  wire logic        push_ready,
   output item_type         push_item
);

   logic                          valid_ff, valid_in;
   item_type                      item_ff, item_in;
   logic [MAX_LANES-1:0][15:0]    lanes_all;

   assign lanes_all = {value_lane3, value_lane2, value_lane1, value_lane0};

   // classify: flag features past the table so the back end skips them
   always_comb begin
      item_in.first_step    = first_step;
      item_in.feature_index = feature_index;
      item_in.in_range      = ({3'b000, feature_index} < FEATURES_LIM);
      item_in.query_feature = query_feature;
      item_in.key_feature   = key_feature;
      for (int l = 0; l < VALUE_LANES; l++) begin
         item_in.value[l] = lanes_all[l];
      end
      item_in.last_feature  = last_feature;
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/clafc_queue.sv
`default_nettype none
`include "assert_macros.svh"
module clafc_queue
   import clafc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  item_type  push_item,
   output logic      head_valid,
   input  wire logic pop,
   output item_type  head_item
);

   item_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 push;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CLAFC_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QDEPTH))
   `CLAFC_NEVER(a_pop_empty, clock, reset, pop && (count_ff == '0))
   `CLAFC_ASSERT(a_count_track, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))

endmodule
`default_nettype wire

### rtl/core/clafc_back.sv
`default_nettype none
`include "assert_macros.svh"
module clafc_back
   import clafc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  item_type                     head_item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [MAX_LANES-1:0][47:0]   rsp_numerator,
   output logic [47:0]                  rsp_denominator
);

   back_state_type st_ff, st_in;
   item_type       cur_ff;

   // row and key sum tables, contents undefined until first written
   logic [VALUE_LANES*32-1:0] kv_mem [FEATURES];
   logic [31:0]               ks_mem [FEATURES];
   logic [VALUE_LANES*32-1:0] kv_rd_ff;
   logic [31:0]               ks_rd_ff;
   logic [FEAT_IDX_W-1:0]     rd_addr, wr_addr;

   logic signed [31:0] prod_ff [VALUE_LANES];
   logic signed [31:0] prod_in [VALUE_LANES];
   logic signed [31:0] row_ff  [VALUE_LANES];
   logic signed [31:0] row_in  [VALUE_LANES];
   logic signed [31:0] ks_ff, ks_in;
   logic signed [47:0] pq_ff   [VALUE_LANES];
   logic signed [47:0] pq_in   [VALUE_LANES];
   logic signed [47:0] pk_ff, pk_in;
   logic signed [47:0] num_acc_ff [VALUE_LANES];
   logic signed [47:0] num_acc_in [VALUE_LANES];
   logic signed [47:0] den_acc_ff, den_acc_in;
   logic signed [47:0] num_out_ff [VALUE_LANES];
   logic signed [47:0] den_out_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_LANES*32-1:0] kv_wdata;

   logic out_free, mem_we, acc_upd, emit;
   logic acc_stall;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign acc_stall = (st_ff == BK_ACC) && cur_ff.last_feature && !out_free;
   assign rd_addr   = head_item.feature_index[FEAT_IDX_W-1:0];
   assign wr_addr   = cur_ff.feature_index[FEAT_IDX_W-1:0];

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: begin
            if (head_valid) begin
               st_in = BK_READ;
            end
         end
         BK_READ: st_in = BK_MUL;
         BK_MUL:  st_in = BK_ACC;
         BK_ACC: begin
            if (!cur_ff.last_feature || out_free) begin
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop     = 1'b0;
      mem_we  = 1'b0;
      acc_upd = 1'b0;
      emit    = 1'b0;
      unique case (st_ff)
         BK_IDLE: pop    = head_valid;
         BK_READ: ;
         BK_MUL:  mem_we = cur_ff.in_range;
         BK_ACC: begin
            acc_upd = !cur_ff.last_feature || out_free;
            emit    = cur_ff.last_feature && out_free;
         end
         default: ;
      endcase
   end

   // datapath: k*v, row and key-sum update, q*row and q*key-sum, accumulate
   always_comb begin
      logic signed [32:0] pr_wide;
      logic signed [24:0] pr_rnd;
      logic signed [33:0] row_sum;
      logic signed [33:0] key_ext;
      logic signed [33:0] ks_sum;
      logic signed [48:0] rnd_wide;
      logic signed [36:0] rnd;
      logic signed [48:0] acc_sum;
      for (int l = 0; l < VALUE_LANES; l++) begin
         prod_in[l] = $signed(head_item.key_feature) * $signed(head_item.value[l]);
         pr_wide    = {prod_ff[l][31], prod_ff[l]} + 33'sd128;
         pr_rnd     = pr_wide[32:8];
         if (cur_ff.first_step) begin
            row_sum = {{9{pr_rnd[24]}}, pr_rnd};
         end else begin
            row_sum = {{2{kv_rd_ff[l*32+31]}}, kv_rd_ff[l*32 +: 32]}
                      + {{9{pr_rnd[24]}}, pr_rnd};
         end
         row_in[l]   = sat32(row_sum);
         kv_wdata[l*32 +: 32] = row_ff[l];
         pq_in[l]    = $signed(cur_ff.query_feature) * row_ff[l];
         rnd_wide    = {pq_ff[l][47], pq_ff[l]} + 49'sd2048;
         rnd         = rnd_wide[48:12];
         acc_sum     = {num_acc_ff[l][47], num_acc_ff[l]} + {{12{rnd[36]}}, rnd};
         num_acc_in[l] = cur_ff.in_range ? sat48(acc_sum) : num_acc_ff[l];
      end
      key_ext = {{14{cur_ff.key_feature[15]}}, cur_ff.key_feature, 4'b0000};
      if (cur_ff.first_step) begin
         ks_sum = key_ext;
      end else begin
         ks_sum = {{2{ks_rd_ff[31]}}, ks_rd_ff} + key_ext;
      end
      ks_in      = sat32(ks_sum);
      pk_in      = $signed(cur_ff.query_feature) * ks_ff;
      rnd_wide   = {pk_ff[47], pk_ff} + 49'sd2048;
      rnd        = rnd_wide[48:12];
      acc_sum    = {den_acc_ff[47], den_acc_ff} + {{12{rnd[36]}}, rnd};
      den_acc_in = cur_ff.in_range ? sat48(acc_sum) : den_acc_ff;
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // tables: write the updated row while the next read waits for the queue
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kv_mem[wr_addr] <= kv_wdata;
         ks_mem[wr_addr] <= ks_ff;
      end
      kv_rd_ff <= kv_mem[rd_addr];
      ks_rd_ff <= ks_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         den_acc_ff   <= '0;
         for (int l = 0; l < VALUE_LANES; l++) begin
            num_acc_ff[l] <= '0;
         end
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            den_acc_ff <= '0;
            for (int l = 0; l < VALUE_LANES; l++) begin
               num_acc_ff[l] <= '0;
            end
         end else if (acc_upd) begin
            den_acc_ff <= den_acc_in;
            for (int l = 0; l < VALUE_LANES; l++) begin
               num_acc_ff[l] <= num_acc_in[l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_item;
         for (int l = 0; l < VALUE_LANES; l++) begin
            prod_ff[l] <= prod_in[l];
         end
      end
      if (st_ff == BK_READ) begin
         ks_ff <= ks_in;
         for (int l = 0; l < VALUE_LANES; l++) begin
            row_ff[l] <= row_in[l];
         end
      end
      if (st_ff == BK_MUL) begin
         pk_ff <= pk_in;
         for (int l = 0; l < VALUE_LANES; l++) begin
            pq_ff[l] <= pq_in[l];
         end
      end
      if (emit) begin
         den_out_ff <= den_acc_in;
         for (int l = 0; l < VALUE_LANES; l++) begin
            num_out_ff[l] <= num_acc_in[l];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_denominator = den_out_ff;

   always_comb begin
      for (int l = 0; l < MAX_LANES; l++) begin
         rsp_numerator[l] = '0;
      end
      for (int l = 0; l < VALUE_LANES; l++) begin
         rsp_numerator[l] = num_out_ff[l];
      end
   end

   `CLAFC_ASSERT(a_hold_acc, clock, reset, acc_stall |=> (st_ff == BK_ACC))
   `CLAFC_ASSERT(a_clear_emit, clock, reset, emit |=> (den_acc_ff == '0))
   `CLAFC_ASSERT(a_rsp_from_acc, clock, reset, $rose(rsp_valid_ff) |-> $past(st_ff == BK_ACC))

endmodule
`default_nettype wire

### bench/tb_top.sv
`default_nettype none
module tb_top
   import clafc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Stop feeding random beats once about this many have gone in.
   localparam int BEAT_TARGET  = 2000;
   // Beats per random phase before the sender parks and lets results drain.
   localparam int PHASE_BEATS  = 180;
   // Length of the one long step that drives rows into saturation.
   localparam int HAMMER_BEATS = 560;
   // Cycles the receiver refuses results while the sender floods the block.
   localparam int HOLD_CYCLES  = 80;
   // Cycles to let pass after the last expected result, before the verdict.
   localparam int TAIL_CYCLES  = 40;

   localparam longint ROW_MAX = 64'sd2147483647;
   localparam longint ROW_MIN = -64'sd2147483648;
   localparam longint ACC_MAX = 64'sd140737488355327;
   localparam longint ACC_MIN = -64'sd140737488355328;

   // Idle settings, one per phase of the random part.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One input beat: a single feature of one time step.
   typedef struct packed {
      logic              first_step;
      logic [5:0]        feature_index;
      logic [15:0]       query;
      logic [15:0]       key;
      logic [3:0][15:0]  value;
      logic              last_feature;
   } feature_beat_type;

   // One result beat: four numerator lanes and the denominator.
   typedef struct packed {
      logic [3:0][47:0]  numer;
      logic [47:0]       denom;
   } attn_sums_type;

   // Running prefix sums of the attention step, plus the queue of step sums
   // that the block still owes us.
   class attn_sum_board_type;
      longint         kv_rows [FEATURES][MAX_LANES];
      longint         key_run [FEATURES];
      longint         num_run [MAX_LANES];
      longint         den_run;
      attn_sums_type  pending_sums [$];
      int             faults;

      // Arithmetic shift right by s with round half up.
      static function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      static function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void note_fault(string what, logic [47:0] want, logic [47:0] got);
         faults++;
         $display("%0t %s mismatch: expected %0d, actual %0d",
                  $time, what, $signed(want), $signed(got));
      endfunction

      // Fold one accepted beat into the sums; queue a result on the last feature.
      function void absorb(feature_beat_type b);
         longint        q;
         longint        k;
         longint        v;
         longint        row;
         longint        ks;
         int            f;
         attn_sums_type sums;
         f = b.feature_index;
         q = longint'($signed(b.query));
         k = longint'($signed(b.key));
         if (f < FEATURES) begin
            for (int l = 0; l < VALUE_LANES && l < MAX_LANES; l++) begin
               v = longint'($signed(b.value[l]));
               row = round_shift(k * v, 8);
               if (!b.first_step) begin
                  row = kv_rows[f][l] + row;
               end
               row = clip(row, ROW_MIN, ROW_MAX);
               kv_rows[f][l] = row;
               num_run[l] = clip(num_run[l] + round_shift(q * row, 12), ACC_MIN, ACC_MAX);
            end
            ks = b.first_step ? k * 16 : key_run[f] + k * 16;
            ks = clip(ks, ROW_MIN, ROW_MAX);
            key_run[f] = ks;
            den_run = clip(den_run + round_shift(q * ks, 12), ACC_MIN, ACC_MAX);
         end
         if (b.last_feature) begin
            for (int l = 0; l < MAX_LANES; l++) begin
               sums.numer[l] = num_run[l][47:0];
               num_run[l] = 0;
            end
            sums.denom = den_run[47:0];
            den_run = 0;
            pending_sums.insert(pending_sums.size(), sums);
         end
      endfunction

      // Check one result beat against the oldest owed step sums.
      function void compare(attn_sums_type got);
         attn_sums_type want;
         if (pending_sums.size() == 0) begin
            faults++;
            $display("%0t result beat with nothing pending: num0 %0d den %0d",
                     $time, $signed(got.numer[0]), $signed(got.denom));
            return;
         end
         want = pending_sums.pop_front();
         for (int l = 0; l < MAX_LANES; l++) begin
            if (got.numer[l] !== want.numer[l]) begin
               note_fault($sformatf("numerator%0d", l), want.numer[l], got.numer[l]);
            end
         end
         if (got.denom !== want.denom) begin
            note_fault("denominator", want.denom, got.denom);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_first_step;
   logic [5:0]  req_feature_index;
   logic [15:0] req_query_feature;
   logic [15:0] req_key_feature;
   logic [15:0] req_value_lane0;
   logic [15:0] req_value_lane1;
   logic [15:0] req_value_lane2;
   logic [15:0] req_value_lane3;
   logic        req_last_feature;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [47:0] rsp_numerator0;
   logic [47:0] rsp_numerator1;
   logic [47:0] rsp_numerator2;
   logic [47:0] rsp_numerator3;
   logic [47:0] rsp_denominator;

   attn_sum_board_type sb;

   // Rows that a first-step beat has written since reset; a beat with
   // first_step low may only touch these.
   bit  row_written [FEATURES];
   int  beats_sent;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   int  hold_left;
   int  phase;
   int  phase_end;

   causal_linear_attention_forward_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_step    (req_first_step),
      .req_feature_index (req_feature_index),
      .req_query_feature (req_query_feature),
      .req_key_feature   (req_key_feature),
      .req_value_lane0   (req_value_lane0),
      .req_value_lane1   (req_value_lane1),
      .req_value_lane2   (req_value_lane2),
      .req_value_lane3   (req_value_lane3),
      .req_last_feature  (req_last_feature),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_numerator0    (rsp_numerator0),
      .rsp_numerator1    (rsp_numerator1),
      .rsp_numerator2    (rsp_numerator2),
      .rsp_numerator3    (rsp_numerator3),
      .rsp_denominator   (rsp_denominator)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: stall at random per the current phase; on request, hold off
   // for a long stretch so the block backs up and drops req_ready.
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Result monitor: sample at the rising edge, check every accepted beat.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.compare({rsp_numerator3, rsp_numerator2, rsp_numerator1,
                        rsp_numerator0, rsp_denominator});
         end
      end
   end

   // Mostly full-range values, with a heavy share of the extremes, zero and minus one.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic feature_beat_type make_beat(
      logic first, logic [5:0] f, logic [15:0] q, logic [15:0] k,
      logic [15:0] v0, logic [15:0] v1, logic [15:0] v2, logic [15:0] v3,
      logic last);
      feature_beat_type b;
      b.first_step    = first;
      b.feature_index = f;
      b.query         = q;
      b.key           = k;
      b.value         = {v3, v2, v1, v0};
      b.last_feature  = last;
      return b;
   endfunction

   function automatic void set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 84; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default:       begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
   endfunction

   // Offer one beat: idle at random first, then hold valid and payload until
   // the block takes it. Valid stays high afterward for a back-to-back beat.
   task automatic send_beat(feature_beat_type b);
      if (b.first_step && b.feature_index < FEATURES) begin
         row_written[b.feature_index] = 1'b1;
      end
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_first_step    <= b.first_step;
      req_feature_index <= b.feature_index;
      req_query_feature <= b.query;
      req_key_feature   <= b.key;
      req_value_lane0   <= b.value[0];
      req_value_lane1   <= b.value[1];
      req_value_lane2   <= b.value[2];
      req_value_lane3   <= b.value[3];
      req_last_feature  <= b.last_feature;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.absorb(b);
      beats_sent++;
   endtask

   // Drop valid and wait until every owed result has come back.
   task automatic park_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_sums.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // A well-formed sequence: the first step overwrites each row of its
   // feature set, later steps accumulate into the same rows. Value lanes
   // are shared by every feature of a step.
   task automatic run_sequence();
      int          width;
      int          steps;
      int          feats [FEATURES];
      logic [15:0] v [4];
      width = ($urandom_range(19) == 0) ? FEATURES : $urandom_range(1, 6);
      steps = $urandom_range(1, 5);
      for (int i = 0; i < width; i++) begin
         feats[i] = (width == FEATURES) ? i : $urandom_range(FEATURES - 1);
      end
      for (int s = 0; s < steps; s++) begin
         foreach (v[l]) v[l] = pick_sample();
         for (int i = 0; i < width; i++) begin
            send_beat(make_beat(s == 0, 6'(feats[i]), pick_sample(), pick_sample(),
                                v[0], v[1], v[2], v[3], i == width - 1));
         end
      end
   endtask

   // A stray beat: random flags, but never a read of an unwritten row.
   task automatic send_noise();
      int   f;
      logic first;
      f = $urandom_range(63);
      first = (f < FEATURES && row_written[f]) ? 1'($urandom_range(1)) : 1'b1;
      send_beat(make_beat(first, 6'(f), pick_sample(), pick_sample(), pick_sample(),
                          pick_sample(), pick_sample(), pick_sample(),
                          $urandom_range(2) == 0));
   endtask

   // One row hammered with the most negative key in a long step: lanes 0 and 2
   // climb to the positive rail, lanes 1 and 3 fall to the negative one.
   task automatic hammer_row();
      logic [5:0]  f;
      logic [15:0] q;
      f = 6'($urandom_range(FEATURES - 1));
      send_beat(make_beat(1'b1, f, pick_sample(), 16'h8000, 16'h8000, 16'h7FFF,
                          16'h8000, 16'h7FFF, 1'b1));
      for (int i = 0; i < HAMMER_BEATS; i++) begin
         q = 16'($urandom);
         send_beat(make_beat(1'b0, f, q, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                             16'h7FFF, i == HAMMER_BEATS - 1));
      end
   endtask

   // Fill the block while the receiver holds off: one-feature steps, each
   // closing a result, offered back to back.
   task automatic flood_under_hold();
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) begin
         send_beat(make_beat(1'b1, 6'($urandom_range(63)), pick_sample(), pick_sample(),
                             pick_sample(), pick_sample(), pick_sample(),
                             pick_sample(), 1'b1));
      end
   endtask

   initial begin
      sb = new;
      beats_sent        = 0;
      hold_request      = 1'b0;
      set_idling(IDLE_NONE);
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_first_step    = 1'b0;
      req_feature_index = '0;
      req_query_feature = '0;
      req_key_feature   = '0;
      req_value_lane0   = '0;
      req_value_lane1   = '0;
      req_value_lane2   = '0;
      req_value_lane3   = '0;
      req_last_feature  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, no idling.
      // Extremes on the lowest and highest feature, first step then a
      // second step that accumulates into the same rows.
      send_beat(make_beat(1'b1, 6'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h0000, 16'hFFFF, 1'b0));
      send_beat(make_beat(1'b1, 6'd63, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                          16'h0000, 16'hFFFF, 1'b1));
      send_beat(make_beat(1'b0, 6'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                          16'hFFFF, 16'h0001, 1'b0));
      send_beat(make_beat(1'b0, 6'd63, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                          16'hFFFF, 16'h0001, 1'b1));
      // Alternating bit patterns on every field.
      send_beat(make_beat(1'b1, 6'd21, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                          16'h5555, 16'hAAAA, 1'b1));
      send_beat(make_beat(1'b1, 6'd42, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                          16'hAAAA, 16'h5555, 1'b1));
      // Products that land exactly on a rounding half in lanes 0 and 1, both signs.
      send_beat(make_beat(1'b1, 6'd5, 16'h0001, 16'h0001, 16'h0080, 16'hFF80,
                          16'h007F, 16'hFF7F, 1'b1));
      // Same feature twice within one step.
      send_beat(make_beat(1'b0, 6'd5, 16'h0800, 16'h0001, 16'h0080, 16'hFF80,
                          16'h007F, 16'hFF7F, 1'b0));
      send_beat(make_beat(1'b0, 6'd5, 16'hF800, 16'hFFFF, 16'h0080, 16'hFF80,
                          16'h007F, 16'hFF7F, 1'b1));
      // All zero, then a read of the zero row with a full-scale query.
      send_beat(make_beat(1'b1, 6'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, 1'b1));
      send_beat(make_beat(1'b0, 6'd1, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, 1'b1));
      // Small distinct lanes across the lowest and highest rows.
      send_beat(make_beat(1'b0, 6'd0, 16'h0001, 16'h7FFF, 16'h0001, 16'h0002,
                          16'h0003, 16'h0004, 1'b0));
      send_beat(make_beat(1'b0, 6'd63, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h0002,
                          16'h0003, 16'h0004, 1'b1));
      park_until_drained();

      // Random part: rotate through the idle settings, park between phases.
      phase = 0;
      while (beats_sent < BEAT_TARGET) begin
         set_idling(idle_mode_type'(phase % 4));
         if (phase == 0) begin
            flood_under_hold();
         end
         if (phase == 5) begin
            hammer_row();
         end
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            if ($urandom_range(9) == 0) begin
               send_noise();
            end else begin
               run_sequence();
            end
         end
         park_until_drained();
         phase++;
      end

      // Let any stray late beat show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.faults == 0 && sb.pending_sums.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/clafc_pkg.sv
rtl/core/clafc_front.sv
rtl/core/clafc_queue.sv
rtl/core/clafc_back.sv
rtl/core/causal_linear_attention_forward_core.sv
bench/tb_top.sv
